// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ilid_pkg.sv -----
// ----------------------------------------------------------------------------
// ilid_pkg
// Types and constants of the indexed list block.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 7;
  localparam int CMD_W   = 3;

  // Request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_READ     = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_INS_POS  = 3'd3,
    CMD_DELETE   = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle action of the cell row
  typedef enum logic [1:0] {
    SH_HOLD   = 2'd0,
    SH_INSERT = 2'd1,
    SH_DELETE = 2'd2
  } shift_e;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;
  } out_word_t;

  // Broadcast to every cell
  typedef struct packed {
    shift_e            op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/indexed_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// Ordered list of signed 32-bit values with read, insert and delete by position.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY register cells. On an insert the cell at
// the position loads the new value and every cell above it takes its lower
// neighbor's entry; on a delete every cell from the position up takes its upper
// neighbor's entry, all in the same cycle. Each word is accepted, the row and
// the entry count update at that edge, and the result word sits in the output
// register the next cycle. A new word is taken every cycle while the output
// side does not stall. Reads select the cell at the position through one mux
// over the row. An in-range insert at a full list returns status 2; positions
// past the count (at or past it for a read or delete) return status 1, and a
// read there returns -1. entry_count carries the low 7 bits of the count.
module indexed_list_insert_delete #(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ilid_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ilid_pkg::out_word_t out_word_o
);
  import ilid_pkg::*;

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]  count_d, count_q;
  logic              out_valid_q;
  out_word_t         out_q, res;
  cell_ctrl_t        ctrl;
  logic              in_acc;
  logic [POS_W:0]    pos9, cnt9, ins_pos9;
  logic [POS_W:0]    cnt_next9;
  logic              is_insert;
  logic [DATA_W-1:0] cell_val [CAPACITY];

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign pos9 = {1'b0, in_word_i.position};
  assign cnt9 = (POS_W + 1)'(count_q);

  // Insert position by request kind
  always_comb begin
    case (in_word_i.command)
      CMD_INS_HEAD: ins_pos9 = '0;
      CMD_INS_TAIL: ins_pos9 = cnt9;
      default:      ins_pos9 = pos9;
    endcase
  end

  // Decode request, form result and cell row action
  always_comb begin
    res.read_data = '0;
    res.status    = ST_DONE;
    count_d       = count_q;
    ctrl.op       = SH_HOLD;
    ctrl.pos      = ins_pos9[POS_W-1:0];
    ctrl.value    = in_word_i.item_value;
    is_insert     = 1'b0;
    case (in_word_i.command)
      CMD_READ: begin
        if (pos9 < cnt9) begin
          res.read_data = cell_val[in_word_i.position[IDX_W-1:0]];
        end else begin
          res.read_data = '1;
          res.status    = ST_RANGE;
        end
      end
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_POS: begin
        is_insert = 1'b1;
        if (ins_pos9 > cnt9) begin
          res.status = ST_RANGE;
        end else if (count_q == CAP_C) begin
          res.status = ST_FULL;
        end else begin
          ctrl.op = SH_INSERT;
          count_d = count_q + 1'b1;
        end
      end
      CMD_DELETE: begin
        ctrl.pos = in_word_i.position;
        if (pos9 >= cnt9) begin
          res.status = ST_RANGE;
        end else begin
          ctrl.op = SH_DELETE;
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
    if (!in_acc) begin
      ctrl.op = SH_HOLD;
      count_d = count_q;
    end
    cnt_next9       = (POS_W + 1)'(count_d);
    res.entry_count = cnt_next9[COUNT_W-1:0];
  end

  // Row of cells, each wired to its neighbors (zero beyond the ends of the row)
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end
    ilid_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_val[i])
    );
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `ASSERT_ALWAYS(a_count_cap, clk_i, rst_ni, count_q <= CAP_C, "count above capacity")
  `ASSERT_NEXT(a_ins_inc, clk_i, rst_ni, in_acc && is_insert && res.status == ST_DONE, count_q == $past(count_q) + 1'b1, "insert did not grow count")
  `ASSERT_NEXT(a_idle_count, clk_i, rst_ni, !in_acc, count_q == $past(count_q), "count moved without a word")
  `ASSERT_NEXT(a_acc_valid, clk_i, rst_ni, in_acc, out_valid_q, "accepted word gave no result")

endmodule

// ----- rtl/core/ilid_cell.sv -----
// ----------------------------------------------------------------------------
// ilid_cell
// One list entry: holds, loads a new value, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module ilid_cell #(
  parameter int IDX = 0
) (
  input  logic                         clk_i,
  input  ilid_pkg::cell_ctrl_t         ctrl_i,
  input  logic [ilid_pkg::DATA_W-1:0]  left_i,
  input  logic [ilid_pkg::DATA_W-1:0]  right_i,
  output logic [ilid_pkg::DATA_W-1:0]  value_o
);
  import ilid_pkg::*;

  localparam logic [POS_W-1:0] IDX_C = POS_W'(IDX);

  logic [DATA_W-1:0] value_d, value_q;

  // Next entry: insert shifts up from the left, delete pulls from the right
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      SH_INSERT: begin
        if (IDX_C == ctrl_i.pos) begin
          value_d = ctrl_i.value;
        end else if (IDX_C > ctrl_i.pos) begin
          value_d = left_i;
        end
      end
      SH_DELETE: begin
        if (IDX_C >= ctrl_i.pos) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ----- sim/indexed_list_insert_delete_checker.sv -----
// ----------------------------------------------------------------------------
// ilid_checker
// Watches both channels of the indexed list block, keeps a shadow copy of
// the list, predicts each result word and compares it field by field.
// ----------------------------------------------------------------------------
module ilid_checker #(
  parameter int CAPACITY = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ilid_pkg::in_word_t  in_word_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ilid_pkg::out_word_t out_word_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  list_len_o
);
  import ilid_pkg::*;

  // Shadow list and the result words still owed by the block
  logic signed [DATA_W-1:0] shadow_entries [CAPACITY];
  int                       shadow_len;
  out_word_t                awaited_words [$];
  int                       fails = 0;

  // Insert with shift-up; position check comes before the full check
  function automatic status_e insert_entry(int at, logic signed [DATA_W-1:0] value);
    int i;
    if (at > shadow_len) return ST_RANGE;
    if (shadow_len >= CAPACITY) return ST_FULL;
    for (i = shadow_len; i > at; i--) shadow_entries[i] = shadow_entries[i-1];
    shadow_entries[at] = value;
    shadow_len++;
    return ST_DONE;
  endfunction

  // Delete with shift-down
  function automatic status_e delete_entry(int at);
    int i;
    if (at >= shadow_len) return ST_RANGE;
    for (i = at; i + 1 < shadow_len; i++) shadow_entries[i] = shadow_entries[i+1];
    shadow_len--;
    return ST_DONE;
  endfunction

  // Apply one request to the shadow list and return the word it yields
  function automatic out_word_t apply_request(in_word_t req);
    out_word_t res;
    int        at;
    res = '0;
    res.status = ST_DONE;
    at = int'(req.position);
    case (req.command)
      CMD_READ: begin
        if (at < shadow_len) begin
          res.read_data = shadow_entries[at];
        end else begin
          res.read_data = -1;
          res.status = ST_RANGE;
        end
      end
      CMD_INS_HEAD: res.status = insert_entry(0, req.item_value);
      CMD_INS_TAIL: res.status = insert_entry(shadow_len, req.item_value);
      CMD_INS_POS:  res.status = insert_entry(at, req.item_value);
      CMD_DELETE:   res.status = delete_entry(at);
      default: ;  // spare codes leave the list alone
    endcase
    res.entry_count = COUNT_W'(shadow_len);
    return res;
  endfunction

  // Results retire before new requests: the block registers each result word when it accepts the request
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    if (!rst_ni) begin
      awaited_words.delete();
      shadow_len = 0;
      pending_o <= 0;
      list_len_o <= 0;
      fail_count_o <= fails;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_words.size() == 0) begin
          $display("%0t: result word with nothing outstanding: %p", $time, out_word_i);
          fails++;
        end else begin
          want = awaited_words.pop_front();
          if (out_word_i.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %0d, got %0d",
                     $time, want.read_data, out_word_i.read_data);
            fails++;
          end
          if (out_word_i.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_word_i.status);
            fails++;
          end
          if (out_word_i.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch, expected %0d, got %0d",
                     $time, want.entry_count, out_word_i.entry_count);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) awaited_words.push_back(apply_request(in_word_i));
      fail_count_o <= fails;
      pending_o <= awaited_words.size();
      list_len_o <= shadow_len;
    end
  end

endmodule

// ----- sim/tb_indexed_list_insert_delete.sv -----
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_delete
// Drives read, insert and delete words into the indexed list block: a short
// directed sweep of edge cases, then random grow, shrink and mixed phases
// with bursty input and a random output stall; ilid_checker scores results.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete;
  import ilid_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int BULK_WORDS   = 1700;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 160;
  localparam int DRAIN_CYCLES = 10;

  typedef enum {PH_GROW, PH_MIXED, PH_SHRINK} bulk_phase_e;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_word;

  int fail_count;
  int pending;
  int list_len;
  int burst_left = 1;
  int idle_cycles = 0;
  bit bulk_started = 1'b0;

  indexed_list_insert_delete #(.CAPACITY(CAPACITY)) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  ilid_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .list_len_o  (list_len)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic in_word_t req(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] value);
    in_word_t w;
    w.command = cmd;
    w.position = pos;
    w.item_value = value;
    return w;
  endfunction

  // Random request shaped by phase; positions track the current list length
  function automatic in_word_t make_request(bulk_phase_e ph, int len);
    in_word_t w;
    int       roll;
    int       ins_pct;
    int       del_pct;
    w.item_value = $urandom();
    w.position = POS_W'($urandom_range(0, len + 1));
    ins_pct = (ph == PH_GROW) ? 60 : (ph == PH_SHRINK) ? 15 : 35;
    del_pct = (ph == PH_GROW) ? 15 : (ph == PH_SHRINK) ? 60 : 35;
    // a few words of pure noise: any code, any position
    if ($urandom_range(0, 99) < 5) begin
      w.command = CMD_W'($urandom_range(0, 2**CMD_W - 1));
      w.position = POS_W'($urandom_range(0, 2**POS_W - 1));
      return w;
    end
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      case ($urandom_range(0, 3))
        0:       w.command = CMD_INS_HEAD;
        1:       w.command = CMD_INS_TAIL;
        default: w.command = CMD_INS_POS;
      endcase
    end else if (roll < ins_pct + del_pct) begin
      w.command = CMD_DELETE;
      w.position = POS_W'($urandom_range(0, len));
    end else begin
      w.command = CMD_READ;
      w.position = POS_W'($urandom_range(0, len));
    end
    return w;
  endfunction

  // Offer one word until taken; most bursts end in a random gap
  task automatic issue(input in_word_t w);
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Stop offering until every result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    bulk_phase_e phase;
    int          phase_left;
    int          phase_idx;
    int          sent;
    int          c;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_word <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, each command and out-of-range refusal
    issue(req(CMD_READ, 8'd0, 32'd0));
    issue(req(CMD_READ, 8'hFF, 32'd0));
    issue(req(CMD_DELETE, 8'd0, 32'd0));
    issue(req(CMD_INS_POS, 8'd1, 32'h1234_5678));
    issue(req(CMD_INS_POS, 8'd0, 32'h7FFF_FFFF));
    issue(req(CMD_INS_HEAD, 8'hFF, 32'h8000_0000));
    issue(req(CMD_INS_TAIL, 8'h00, 32'hFFFF_FFFF));
    issue(req(CMD_INS_POS, 8'd3, 32'd0));
    issue(req(CMD_INS_POS, 8'd2, 32'h5555_5555));
    issue(req(CMD_INS_POS, 8'hFF, 32'hAAAA_AAAA));
    for (c = 0; c <= 5; c++) issue(req(CMD_READ, POS_W'(c), 32'd0));
    for (c = int'(CMD_DELETE) + 1; c < 2**CMD_W; c++) issue(req(CMD_W'(c), 8'hFF, '1));
    issue(req(CMD_DELETE, 8'd4, 32'd0));
    issue(req(CMD_DELETE, 8'd0, 32'd0));
    issue(req(CMD_DELETE, 8'd5, 32'd0));
    issue(req(CMD_READ, 8'd0, 32'd0));
    issue(req(CMD_INS_HEAD, 8'd0, 32'hAAAA_AAAA));
    drain_results();

    // random phases in turn: grow, mix, shrink, mix
    bulk_started <= 1'b1;
    phase_idx = 0;
    phase = PH_GROW;
    phase_left = $urandom_range(80, 220);
    for (sent = 0; sent < BULK_WORDS; sent++) begin
      if (phase_left == 0) begin
        phase_idx++;
        case (phase_idx % 4)
          0:       phase = PH_GROW;
          2:       phase = PH_SHRINK;
          default: phase = PH_MIXED;
        endcase
        phase_left = $urandom_range(80, 220);
      end
      phase_left--;
      issue(make_request(phase, list_len));
      if (sent == BULK_WORDS / 2) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Output stall pattern, with one long hold once the random part runs
  initial begin
    int  mode;
    int  span;
    int  i;
    int  rx_cycles;
    bit  held;
    rx_cycles = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      if (bulk_started && !held && rx_cycles >= 400) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      for (i = 0; i < span; i++) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 9) < 6);
          default: out_stall <= i[0];
        endcase
        @(posedge clk);
        if (bulk_started) rx_cycles++;
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
